>>> src/grv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grv_pkg
// Shared widths, register indexes and saturation helper for the particle
// update pipeline.
// ----------------------------------------------------------------------------
package grv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int CH_W          = 16;
  localparam int ROOT_W        = 32;
  localparam int CFG_IDX_W     = 3;
  localparam logic [30:0] TIME_STEP_RST = 31'd1092;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP   = 3'd0,
    CFG_GRAVITY_X   = 3'd1,
    CFG_GRAVITY_Y   = 3'd2,
    CFG_EMITTER_X   = 3'd3,
    CFG_EMITTER_Y   = 3'd4,
    CFG_MOTION_MODE = 3'd5
  } cfg_idx_e;

  function automatic logic signed [31:0] sat_to32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/grv_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grv_isqrt
// Pipelined 64-bit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module grv_isqrt import grv_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [63:0]       n_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int STEPS = 32;

  logic [63:0]       rem_q  [STEPS];
  logic [63:0]       res_q  [STEPS];
  logic              vld_q  [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam logic [63:0] StepBit = 64'd1 << (62 - 2 * j);
    logic [63:0]       src_rem;
    logic [63:0]       src_res;
    logic              src_vld;
    logic [SIDE_W-1:0] src_side;
    logic [63:0]       trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign src_rem  = n_i;
      assign src_res  = '0;
      assign src_vld  = valid_i;
      assign src_side = side_i;
    end else begin : g_next
      assign src_rem  = rem_q[j-1];
      assign src_res  = res_q[j-1];
      assign src_vld  = vld_q[j-1];
      assign src_side = side_q[j-1];
    end

    assign trial = src_res + StepBit;
    assign ge    = src_rem >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? src_rem - trial : src_rem;
        res_q[j]  <= ge ? (src_res >> 1) + StepBit : src_res >> 1;
        side_q[j] <= src_side;
      end
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign root_o  = res_q[STEPS-1][ROOT_W-1:0];
  assign side_o  = side_q[STEPS-1];

endmodule

>>> src/grv_udiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grv_udiv
// Two-lane pipelined restoring divider giving floor(a * 2^FRAC_BITS / d)
// for a <= d, one quotient bit per stage.
// ----------------------------------------------------------------------------
module grv_udiv import grv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [DATA_W-1:0]    ax_i,
  input  logic [DATA_W-1:0]    ay_i,
  input  logic [ROOT_W-1:0]    d_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [FRAC_BITS:0]   qx_o,
  output logic [FRAC_BITS:0]   qy_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int QW    = FRAC_BITS + 1;
  localparam int RW    = ROOT_W + 1;

  logic [RW-1:0]     rx_q   [QW];
  logic [RW-1:0]     ry_q   [QW];
  logic [QW-1:0]     qx_q   [QW];
  logic [QW-1:0]     qy_q   [QW];
  logic [ROOT_W-1:0] d_q    [QW];
  logic              vld_q  [QW];
  logic [SIDE_W-1:0] side_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [RW-1:0]     src_rx;
    logic [RW-1:0]     src_ry;
    logic [QW-1:0]     src_qx;
    logic [QW-1:0]     src_qy;
    logic [ROOT_W-1:0] src_d;
    logic              src_vld;
    logic [SIDE_W-1:0] src_side;
    logic [RW-1:0]     dext;
    logic              ge_x;
    logic              ge_y;
    logic [RW-1:0]     sub_x;
    logic [RW-1:0]     sub_y;

    if (j == 0) begin : g_first
      assign src_rx   = {1'b0, ax_i};
      assign src_ry   = {1'b0, ay_i};
      assign src_qx   = '0;
      assign src_qy   = '0;
      assign src_d    = d_i;
      assign src_vld  = valid_i;
      assign src_side = side_i;
    end else begin : g_next
      assign src_rx   = rx_q[j-1];
      assign src_ry   = ry_q[j-1];
      assign src_qx   = qx_q[j-1];
      assign src_qy   = qy_q[j-1];
      assign src_d    = d_q[j-1];
      assign src_vld  = vld_q[j-1];
      assign src_side = side_q[j-1];
    end

    assign dext  = {1'b0, src_d};
    assign ge_x  = src_rx >= dext;
    assign ge_y  = src_ry >= dext;
    assign sub_x = ge_x ? src_rx - dext : src_rx;
    assign sub_y = ge_y ? src_ry - dext : src_ry;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= src_vld;
      end
    end

    // remainder stays below the divisor, so the doubled value fits
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[j]   <= {sub_x[RW-2:0], 1'b0};
        ry_q[j]   <= {sub_y[RW-2:0], 1'b0};
        qx_q[j]   <= {src_qx[QW-2:0], ge_x};
        qy_q[j]   <= {src_qy[QW-2:0], ge_y};
        d_q[j]    <= src_d;
        side_q[j] <= src_side;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign qx_o    = qx_q[QW-1];
  assign qy_o    = qy_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

>>> src/gravity_particle_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gravity_particle_update
// Advances one particle record by one time step in gravity mode.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one particle record per request, m_axis returns one
//   updated record per request, in order. m_axis_tuser is the alive flag;
//   a dead particle returns only its new life, all other fields zero.
//   The cfg channel writes time step, gravity, emitter position and motion
//   mode; it is always ready and should only be written while the pipeline
//   is empty.
//   Throughput: one record per cycle while the receiver takes results. The
//   32-stage square root and the FRAC_BITS+1 stage divider normalise the
//   velocity.
//   All stages share one enable: when the output holds a result the
//   receiver is not taking, the whole pipeline and s_axis_tready halt, and
//   nothing is lost or repeated.
//   Reset clears all valid bits and returns the registers to their defaults
//   (time step 1092, everything else zero).
// ----------------------------------------------------------------------------
module gravity_particle_update import grv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // life_left, move_position, velocity, start_position, radial_accel,
  // tangent_accel, color, color_delta, size, size_delta, rotation,
  // rotation_delta, one zero pad bit
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [543:0]         s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // new_life, new_move_position, draw_position, new_velocity, new_color,
  // new_size, new_rotation, one zero pad bit
  output logic [351:0]         m_axis_tdata,
  // alive
  output logic                 m_axis_tuser,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0]    cfg_data_i
);

  localparam int QW = FRAC_BITS + 1;
  localparam int UW = FRAC_BITS + 2;
  localparam int PW = UW + DATA_W;

  typedef struct packed {
    logic               alive;
    logic               use_dir;
    logic signed [31:0] life;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] spx;
    logic signed [31:0] spy;
    logic signed [31:0] ra;
    logic signed [31:0] ta;
    logic [63:0]        color;
    logic [30:0]        size;
    logic signed [31:0] rot;
  } body_t;

  typedef struct packed {
    logic [31:0] axn;
    logic [31:0] ayn;
    body_t       body;
  } sq_side_t;

  localparam int BODY_W = $bits(body_t);
  localparam int SQS_W  = $bits(sq_side_t);

  // configuration registers
  logic [30:0]        time_step_q;
  logic signed [31:0] gravity_x_q, gravity_y_q, emitter_x_q, emitter_y_q;
  logic               motion_mode_q;
  cfg_idx_e           cfg_idx;

  assign cfg_ready_o = 1'b1;
  assign cfg_idx     = cfg_idx_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q   <= TIME_STEP_RST;
      gravity_x_q   <= '0;
      gravity_y_q   <= '0;
      emitter_x_q   <= '0;
      emitter_y_q   <= '0;
      motion_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx)
        CFG_TIME_STEP:   time_step_q   <= cfg_data_i[30:0];
        CFG_GRAVITY_X:   gravity_x_q   <= cfg_data_i;
        CFG_GRAVITY_Y:   gravity_y_q   <= cfg_data_i;
        CFG_EMITTER_X:   emitter_x_q   <= cfg_data_i;
        CFG_EMITTER_Y:   emitter_y_q   <= cfg_data_i;
        CFG_MOTION_MODE: motion_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] dt_s;
  assign dt_s = {1'b0, time_step_q};

  // global pipeline advance
  logic en;
  logic m_valid_q;
  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage 0: input register
  logic         v0_q;
  logic [543:0] in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= s_axis_tdata;
    end
  end

  logic signed [31:0] in_life, in_px, in_py, in_vx, in_vy, in_sdelta, in_rdelta;
  logic [31:0]        in_ax, in_ay, in_m;
  logic signed [32:0] in_vx_neg, in_vy_neg;

  assign in_life   = in_q[31:0];
  assign in_px     = in_q[95:64];
  assign in_py     = in_q[63:32];
  assign in_vx     = in_q[159:128];
  assign in_vy     = in_q[127:96];
  assign in_sdelta = in_q[478:447];
  assign in_rdelta = in_q[542:511];
  assign in_vx_neg = -{in_vx[31], in_vx};
  assign in_vy_neg = -{in_vy[31], in_vy};
  assign in_ax     = in_vx[31] ? in_vx_neg[31:0] : in_vx;
  assign in_ay     = in_vy[31] ? in_vy_neg[31:0] : in_vy;
  assign in_m      = (in_ax > in_ay) ? in_ax : in_ay;

  // ---------------- stage 1: life, delta products, velocity magnitudes
  logic               v1_q;
  logic [543:0]       s1_raw_q;
  logic signed [31:0] s1_life_q;
  logic signed [47:0] s1_cprod_q [4];
  logic signed [63:0] s1_sprod_q, s1_rprod_q;
  logic [31:0]        s1_ax_q, s1_ay_q, s1_m_q;
  logic               s1_pos_nz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_raw_q    <= in_q;
      s1_life_q   <= sat_to32(64'(in_life) - 64'(dt_s));
      for (int c = 0; c < 4; c++) begin
        s1_cprod_q[c] <= $signed(in_q[352 + CH_W*c +: CH_W]) * dt_s;
      end
      s1_sprod_q  <= in_sdelta * dt_s;
      s1_rprod_q  <= in_rdelta * dt_s;
      s1_ax_q     <= in_ax;
      s1_ay_q     <= in_ay;
      s1_m_q      <= in_m;
      s1_pos_nz_q <= (in_px != '0) || (in_py != '0);
    end
  end

  // ---------------- stage 2: finish color, size, rotation; shift amount
  logic [63:0]        s2_color_d;
  logic signed [47:0] csum;
  logic signed [63:0] size_sum, rot_sum;
  logic [30:0]        s2_size_d;
  logic [4:0]         s2_sh_d;
  body_t              s2_body_d;

  always_comb begin
    s2_color_d = '0;
    for (int c = 0; c < 4; c++) begin
      csum = 48'($signed(s1_raw_q[288 + CH_W*c +: CH_W])) + (s1_cprod_q[c] >>> FRAC_BITS);
      if (csum > 48'sd32767) begin
        s2_color_d[CH_W*c +: CH_W] = 16'h7fff;
      end else if (csum < -48'sd32768) begin
        s2_color_d[CH_W*c +: CH_W] = 16'h8000;
      end else begin
        s2_color_d[CH_W*c +: CH_W] = csum[15:0];
      end
    end
    size_sum = 64'($signed({1'b0, s1_raw_q[446:416]})) + (s1_sprod_q >>> FRAC_BITS);
    if (size_sum < 64'sd0) begin
      s2_size_d = '0;
    end else if (size_sum > 64'sd2147483647) begin
      s2_size_d = '1;
    end else begin
      s2_size_d = size_sum[30:0];
    end
    rot_sum = 64'($signed(s1_raw_q[510:479])) + (s1_rprod_q >>> FRAC_BITS);
    // normalising shift brings a nonzero larger magnitude to at least 2^30
    s2_sh_d = '0;
    for (int i = 0; i < 31; i++) begin
      if (s1_m_q[i]) s2_sh_d = 5'(30 - i);
    end
    if (s1_m_q[31]) s2_sh_d = '0;

    s2_body_d.alive   = s1_life_q > 32'sd0;
    s2_body_d.use_dir = s1_pos_nz_q && (s1_m_q != '0);
    s2_body_d.life    = s1_life_q;
    s2_body_d.px      = s1_raw_q[95:64];
    s2_body_d.py      = s1_raw_q[63:32];
    s2_body_d.vx      = s1_raw_q[159:128];
    s2_body_d.vy      = s1_raw_q[127:96];
    s2_body_d.spx     = s1_raw_q[223:192];
    s2_body_d.spy     = s1_raw_q[191:160];
    s2_body_d.ra      = s1_raw_q[255:224];
    s2_body_d.ta      = s1_raw_q[287:256];
    s2_body_d.color   = s2_color_d;
    s2_body_d.size    = s2_size_d;
    s2_body_d.rot     = sat_to32(rot_sum);
  end

  logic        v2_q, v3_q, v4_q, v5_q;
  body_t       s2_body_q, s3_body_q, s4_body_q, s5_body_q;
  logic [31:0] s2_ax_q, s2_ay_q, s3_ax_q, s3_ay_q, s4_ax_q, s4_ay_q, s5_ax_q, s5_ay_q;
  logic [4:0]  s2_sh_q;
  logic [63:0] s4_sqx_q, s4_sqy_q, s5_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stages 3 to 5: shift, square, sum of squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_body_q <= s2_body_d;
      s2_ax_q   <= s1_ax_q;
      s2_ay_q   <= s1_ay_q;
      s2_sh_q   <= s2_sh_d;
      s3_body_q <= s2_body_q;
      s3_ax_q   <= s2_ax_q << s2_sh_q;
      s3_ay_q   <= s2_ay_q << s2_sh_q;
      s4_body_q <= s3_body_q;
      s4_ax_q   <= s3_ax_q;
      s4_ay_q   <= s3_ay_q;
      s4_sqx_q  <= s3_ax_q * s3_ax_q;
      s4_sqy_q  <= s3_ay_q * s3_ay_q;
      s5_body_q <= s4_body_q;
      s5_ax_q   <= s4_ax_q;
      s5_ay_q   <= s4_ay_q;
      s5_sum_q  <= s4_sqx_q + s4_sqy_q;
    end
  end

  // ---------------- magnitude and unit direction
  sq_side_t          sq_side_in, sq_side_out;
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;

  assign sq_side_in = '{axn: s5_ax_q, ayn: s5_ay_q, body: s5_body_q};

  grv_isqrt #(
    .SIDE_W (SQS_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .n_i     (s5_sum_q),
    .side_i  (sq_side_in),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side_out)
  );

  logic              dv_valid;
  logic [QW-1:0]     dv_qx, dv_qy;
  logic [BODY_W-1:0] dv_side;
  body_t             dv_body;

  grv_udiv #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_W    (BODY_W)
  ) u_udiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .ax_i    (sq_side_out.axn),
    .ay_i    (sq_side_out.ayn),
    .d_i     (sq_root),
    .side_i  (sq_side_out.body),
    .valid_o (dv_valid),
    .qx_o    (dv_qx),
    .qy_o    (dv_qy),
    .side_o  (dv_side)
  );

  assign dv_body = body_t'(dv_side);

  logic signed [UW-1:0] ux, uy, ux_mag, uy_mag;
  assign ux_mag = $signed({1'b0, dv_qx});
  assign uy_mag = $signed({1'b0, dv_qy});
  assign ux = !dv_body.use_dir ? '0 : (dv_body.vx[31] ? -ux_mag : ux_mag);
  assign uy = !dv_body.use_dir ? '0 : (dv_body.vy[31] ? -uy_mag : uy_mag);

  // ---------------- stages A to F: forces and integration
  logic               va_q, vb_q, vc_q, vd_q, ve_q, vf_q;
  body_t              ba_q, bb_q, bc_q, bd_q, be_q, bf_q;
  logic signed [PW-1:0] pa_rx_q, pa_ty_q, pa_ry_q, pa_tx_q;
  logic signed [31:0] b_axx_q, b_ayy_q;
  logic signed [63:0] c_mx_q, c_my_q;
  logic signed [31:0] d_vx_q, d_vy_q, e_vx_q, e_vy_q, f_vx_q, f_vy_q;
  logic signed [63:0] e_mx_q, e_my_q;
  logic signed [31:0] f_px_q, f_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en) begin
      va_q <= dv_valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ba_q    <= dv_body;
      pa_rx_q <= ux * dv_body.ra;
      pa_ty_q <= (-uy) * dv_body.ta;
      pa_ry_q <= uy * dv_body.ra;
      pa_tx_q <= ux * dv_body.ta;

      bb_q    <= ba_q;
      b_axx_q <= sat_to32(64'(pa_rx_q >>> FRAC_BITS) + 64'(pa_ty_q >>> FRAC_BITS)
                          + 64'(gravity_x_q));
      b_ayy_q <= sat_to32(64'(pa_ry_q >>> FRAC_BITS) + 64'(pa_tx_q >>> FRAC_BITS)
                          + 64'(gravity_y_q));

      bc_q    <= bb_q;
      c_mx_q  <= b_axx_q * dt_s;
      c_my_q  <= b_ayy_q * dt_s;

      bd_q    <= bc_q;
      d_vx_q  <= sat_to32(64'(bc_q.vx) + (c_mx_q >>> FRAC_BITS));
      d_vy_q  <= sat_to32(64'(bc_q.vy) + (c_my_q >>> FRAC_BITS));

      be_q    <= bd_q;
      e_vx_q  <= d_vx_q;
      e_vy_q  <= d_vy_q;
      e_mx_q  <= d_vx_q * dt_s;
      e_my_q  <= d_vy_q * dt_s;

      bf_q    <= be_q;
      f_vx_q  <= e_vx_q;
      f_vy_q  <= e_vy_q;
      f_px_q  <= sat_to32(64'(be_q.px) + (e_mx_q >>> FRAC_BITS));
      f_py_q  <= sat_to32(64'(be_q.py) + (e_my_q >>> FRAC_BITS));
    end
  end

  // ---------------- output register
  logic signed [31:0] draw_x, draw_y;
  logic [351:0]       out_d;
  logic [351:0]       out_q;
  logic               alive_q;

  always_comb begin
    if (motion_mode_q) begin
      draw_x = sat_to32(64'(f_px_q) + 64'(emitter_x_q) - 64'(bf_q.spx));
      draw_y = sat_to32(64'(f_py_q) + 64'(emitter_y_q) - 64'(bf_q.spy));
    end else begin
      draw_x = f_px_q;
      draw_y = f_py_q;
    end
    out_d = '0;
    out_d[31:0] = bf_q.life;
    if (bf_q.alive) begin
      out_d[95:32]   = {f_px_q, f_py_q};
      out_d[159:96]  = {draw_x, draw_y};
      out_d[223:160] = {f_vx_q, f_vy_q};
      out_d[287:224] = bf_q.color;
      out_d[318:288] = bf_q.size;
      out_d[350:319] = bf_q.rot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q   <= out_d;
      alive_q <= bf_q.alive;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = alive_q;

`ifndef SYNTHESIS
  a_dead_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[351:32] == '0)
    else $error("dead particle carries non-zero fields");

  a_alive_life_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[31] && m_axis_tdata[31:0] != '0)
    else $error("alive particle with non-positive life");

  a_free_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !motion_mode_q |-> m_axis_tdata[159:96] == m_axis_tdata[95:32])
    else $error("free mode draw position differs from move position");

  a_stall_holds_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(va_q) && $stable(vf_q) && $stable(v0_q))
    else $error("pipeline moved during a stall");
`endif

endmodule
